// ===== hdl/wrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wrts_pkg;

	localparam int NUM_LEVELS = 5;
	localparam int LEVEL_W = $clog2(NUM_LEVELS);
	localparam logic [2:0] NICE_MAX = 3'd4;

	typedef logic [15:0] weight_t;

	localparam weight_t WEIGHT_RESET [NUM_LEVELS] = '{
		16'd256, 16'd320, 16'd400, 16'd500, 16'd625
	};

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  nice;
		logic [31:0] runtime;
	} entry_t;

	typedef enum logic [1:0] {
		KIND_ADD      = 2'd0,
		KIND_DISPATCH = 2'd1,
		KIND_TICK     = 2'd2,
		KIND_REMOVE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_EMPTY      = 2'd1,
		STATUS_FULL       = 2'd2,
		STATUS_NO_CURRENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHARGE,
		ST_REQUEUE
	} state_t;

	// broadcast to every cell of the sorted row
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t data;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/weighted_runtime_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// add, dispatch and remove-first: done is registered in exec, the state after the start request
// tick: done comes from exec with no current task, else from charge, or from requeue
// after charge has popped the head; a new request is taken only back in idle,
// after the op's last step, and busy is high until then
// the sorted row moves all its entries together, one comparator per cell
// arst_n clears the row's valid bits, the current-task flag and count, and loads the reset weights

module weighted_runtime_task_scheduler #(
	parameter int MAX_TASKS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  kind,
	input  wire  [15:0] task_id,
	input  wire  [2:0]  nice_level,
	input  wire  [31:0] initial_runtime,
	output logic        done,
	output logic [15:0] out_task_id,
	output logic [2:0]  out_nice_level,
	output logic [31:0] out_runtime,
	output logic        task_given,
	output logic [1:0]  status,
	output logic [5:0]  queued_count,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import wrts_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);

	state_t     state_q, state_nx;
	kind_t      kind_q;
	entry_t     new_q, charged_q, cur_q, res_q;
	logic       cur_valid_q, given_q, done_q;
	status_t    status_q;
	logic [CW-1:0] count_q;
	weight_t    weights_q [NUM_LEVELS];

	cell_ctrl_t ctrl;
	entry_t     cell_entry [MAX_TASKS];
	logic       cell_valid [MAX_TASKS];
	logic       cell_le    [MAX_TASKS];

	logic       full, take_head;
	logic [32:0] sum;
	entry_t     charged;

	assign full      = (count_q == CW'(MAX_TASKS));
	assign take_head = cell_valid[0] && !(charged_q.runtime < cell_entry[0].runtime);

	always_comb begin
		sum = {1'b0, cur_q.runtime} + {17'd0, weights_q[cur_q.nice[LEVEL_W-1:0]]};
		charged = cur_q;
		charged.runtime = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
			entry_t l_entry, r_entry;
			logic   l_valid, l_le, r_valid;
			if (gi == 0) begin : g_first
				assign l_entry = '0;
				assign l_valid = 1'b1;
				assign l_le    = 1'b1;
			end else begin : g_mid
				assign l_entry = cell_entry[gi-1];
				assign l_valid = cell_valid[gi-1];
				assign l_le    = cell_le[gi-1];
			end
			if (gi == MAX_TASKS - 1) begin : g_last
				assign r_entry = '0;
				assign r_valid = 1'b0;
			end else begin : g_inner
				assign r_entry = cell_entry[gi+1];
				assign r_valid = cell_valid[gi+1];
			end
			wrts_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_entry  (l_entry),
				.left_valid  (l_valid),
				.left_le     (l_le),
				.right_entry (r_entry),
				.right_valid (r_valid),
				.entry       (cell_entry[gi]),
				.valid       (cell_valid[gi]),
				.le          (cell_le[gi])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_nx = ST_EXEC;
			ST_EXEC:    state_nx = (kind_q == KIND_TICK && cur_valid_q) ? ST_CHARGE : ST_IDLE;
			ST_CHARGE:  state_nx = take_head ? ST_REQUEUE : ST_IDLE;
			ST_REQUEUE: state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// row control
	always_comb begin
		ctrl.ins  = 1'b0;
		ctrl.pop  = 1'b0;
		ctrl.data = new_q;
		unique case (state_q)
			ST_EXEC: begin
				unique case (kind_q)
					KIND_ADD:                ctrl.ins = !full;
					KIND_DISPATCH, KIND_REMOVE: ctrl.pop = cell_valid[0];
					default:                 ctrl.pop = 1'b0;
				endcase
			end
			ST_CHARGE: ctrl.pop = take_head;
			ST_REQUEUE: begin
				ctrl.ins  = 1'b1;
				ctrl.data = charged_q;
			end
			default: ctrl.ins = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_valid_q <= 1'b0;
			count_q     <= '0;
			done_q      <= 1'b0;
			for (int i = 0; i < NUM_LEVELS; i++) weights_q[i] <= WEIGHT_RESET[i];
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			if (cfg_valid && 32'(cfg_index) < NUM_LEVELS) begin
				weights_q[cfg_index[LEVEL_W-1:0]] <= cfg_data;
			end
			unique case (state_q)
				ST_EXEC: begin
					unique case (kind_q)
						KIND_ADD: begin
							done_q <= 1'b1;
							if (!full) count_q <= count_q + 1'b1;
						end
						KIND_DISPATCH: begin
							done_q      <= 1'b1;
							cur_valid_q <= cell_valid[0];
							if (cell_valid[0]) count_q <= count_q - 1'b1;
						end
						KIND_TICK: begin
							if (!cur_valid_q) done_q <= 1'b1;
						end
						KIND_REMOVE: begin
							done_q <= 1'b1;
							if (cell_valid[0]) count_q <= count_q - 1'b1;
						end
						default: done_q <= 1'b0;
					endcase
				end
				ST_CHARGE: begin
					if (take_head) count_q <= count_q - 1'b1;
					else done_q <= 1'b1;
				end
				ST_REQUEUE: begin
					count_q <= count_q + 1'b1;
					done_q  <= 1'b1;
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	// payload and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q          <= kind_t'(kind);
					new_q.id        <= task_id;
					new_q.nice      <= (nice_level > NICE_MAX) ? NICE_MAX : nice_level;
					new_q.runtime   <= initial_runtime;
				end
			end
			ST_EXEC: begin
				res_q    <= '0;
				given_q  <= 1'b0;
				status_q <= STATUS_OK;
				unique case (kind_q)
					KIND_ADD: begin
						if (full) status_q <= STATUS_FULL;
					end
					KIND_DISPATCH: begin
						if (cell_valid[0]) begin
							cur_q   <= cell_entry[0];
							res_q   <= cell_entry[0];
							given_q <= 1'b1;
						end else begin
							cur_q    <= '0;
							status_q <= STATUS_EMPTY;
						end
					end
					KIND_TICK: begin
						if (cur_valid_q) charged_q <= charged;
						else status_q <= STATUS_NO_CURRENT;
					end
					KIND_REMOVE: begin
						if (cell_valid[0]) begin
							res_q   <= cell_entry[0];
							given_q <= 1'b1;
						end else begin
							status_q <= STATUS_EMPTY;
						end
					end
					default: given_q <= 1'b0;
				endcase
			end
			ST_CHARGE: begin
				given_q <= 1'b1;
				if (take_head) begin
					cur_q <= cell_entry[0];
					res_q <= cell_entry[0];
				end else begin
					cur_q <= charged_q;
					res_q <= charged_q;
				end
			end
			default: given_q <= given_q;
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = done_q;
	assign out_task_id    = res_q.id;
	assign out_nice_level = res_q.nice;
	assign out_runtime    = res_q.runtime;
	assign task_given     = given_q;
	assign status         = status_q;
	assign queued_count   = 6'(count_q);

endmodule

`default_nettype wire

// ===== hdl/wrts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wrts_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire wrts_pkg::cell_ctrl_t ctrl,
	input  wire wrts_pkg::entry_t left_entry,
	input  wire                  left_valid,
	input  wire                  left_le,
	input  wire wrts_pkg::entry_t right_entry,
	input  wire                  right_valid,
	output wrts_pkg::entry_t     entry,
	output logic                 valid,
	output logic                 le
);
	import wrts_pkg::*;

	entry_t entry_q;
	logic   valid_q;

	// entry stays put if it sorts at or before the new one (keeps insertion order on ties)
	assign le    = valid_q && (entry_q.runtime <= ctrl.data.runtime);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.ins && !le) begin
			valid_q <= left_le ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= right_entry;
		end else if (ctrl.ins && !le) begin
			entry_q <= left_le ? ctrl.data : left_entry;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wrts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wrts_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [15:0] out_task_id,
	input wire [2:0]  out_nice_level,
	input wire [31:0] out_runtime,
	input wire        task_given,
	input wire [1:0]  status
);
	import wrts_pkg::*;

	// an accepted request always occupies the block for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// a result is only shown once the block has gone back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(done))
		else $error("result strobe while busy or repeated");

	// a reported task always comes with ok status
	a_given_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && task_given |-> status == STATUS_OK)
		else $error("task given with error status");

	// no task means all-zero task fields
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !task_given |-> out_task_id == 16'd0 && out_nice_level == 3'd0
			&& out_runtime == 32'd0)
		else $error("task fields nonzero without a task");

endmodule

bind weighted_runtime_task_scheduler wrts_checker u_wrts_checker (.*);

`default_nettype wire

// ===== dv/tb_weighted_runtime_task_scheduler.sv =====
`timescale 1ns / 1ps

module tb_weighted_runtime_task_scheduler;
	import wrts_pkg::*;

	localparam int MAX_TASKS = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [2:0] {
		REG_WEIGHT_LEVEL0 = 3'd0,
		REG_WEIGHT_LEVEL1 = 3'd1,
		REG_WEIGHT_LEVEL2 = 3'd2,
		REG_WEIGHT_LEVEL3 = 3'd3,
		REG_WEIGHT_LEVEL4 = 3'd4
	} weight_reg_t;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  nice;
		logic [31:0] runtime;
		logic        given;
		status_t     status;
		logic [5:0]  count;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [15:0] task_id;
	logic [2:0]  nice_level;
	logic [31:0] initial_runtime;
	logic        done;
	logic [15:0] out_task_id;
	logic [2:0]  out_nice_level;
	logic [31:0] out_runtime;
	logic        task_given;
	logic [1:0]  status;
	logic [5:0]  queued_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// scheduler state as predicted
	entry_t        ready_tasks [$];
	entry_t        running_task;
	logic          running_valid;
	weight_t       level_weight [NUM_LEVELS];
	sched_result_t expected_results [$];

	int unsigned   mismatch_count;
	int unsigned   cycle_count;
	bit            gaps_enabled;
	sched_result_t exp_res;
	sched_result_t got_res;

	weighted_runtime_task_scheduler #(
		.MAX_TASKS(MAX_TASKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.task_id(task_id),
		.nice_level(nice_level),
		.initial_runtime(initial_runtime),
		.done(done),
		.out_task_id(out_task_id),
		.out_nice_level(out_nice_level),
		.out_runtime(out_runtime),
		.task_given(task_given),
		.status(status),
		.queued_count(queued_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stable insert: after every waiting task whose runtime is <= its own
	function automatic void insert_by_runtime(entry_t e);
		int pos;
		pos = 0;
		while (pos < ready_tasks.size() && ready_tasks[pos].runtime <= e.runtime)
			pos++;
		ready_tasks.insert(pos, e);
	endfunction

	function automatic sched_result_t schedule_op(kind_t op, logic [15:0] id,
			logic [2:0] nice, logic [31:0] runtime);
		sched_result_t r;
		entry_t        e;
		logic [32:0]   charged;
		r = '0;
		r.status = STATUS_OK;
		case (op)
			KIND_ADD: begin
				if (ready_tasks.size() >= MAX_TASKS) begin
					r.status = STATUS_FULL;
				end else begin
					e.id = id;
					e.nice = (nice > NICE_MAX) ? NICE_MAX : nice;
					e.runtime = runtime;
					insert_by_runtime(e);
				end
			end
			KIND_DISPATCH: begin
				if (ready_tasks.size() > 0) begin
					running_task = ready_tasks.pop_front();
					running_valid = 1'b1;
					r.id = running_task.id;
					r.nice = running_task.nice;
					r.runtime = running_task.runtime;
					r.given = 1'b1;
				end else begin
					running_task = '0;
					running_valid = 1'b0;
					r.status = STATUS_EMPTY;
				end
			end
			KIND_TICK: begin
				if (!running_valid) begin
					r.status = STATUS_NO_CURRENT;
				end else begin
					e = running_task;
					charged = {1'b0, e.runtime} + {17'd0, level_weight[e.nice]};
					e.runtime = charged[32] ? 32'hFFFF_FFFF : charged[31:0];
					insert_by_runtime(e);
					running_task = ready_tasks.pop_front();
					r.id = running_task.id;
					r.nice = running_task.nice;
					r.runtime = running_task.runtime;
					r.given = 1'b1;
				end
			end
			default: begin
				if (ready_tasks.size() > 0) begin
					e = ready_tasks.pop_front();
					r.id = e.id;
					r.nice = e.nice;
					r.runtime = e.runtime;
					r.given = 1'b1;
				end else begin
					r.status = STATUS_EMPTY;
				end
			end
		endcase
		r.count = 6'(ready_tasks.size());
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (!gaps_enabled || sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic idle_for(int unsigned cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic send_request(kind_t op, logic [15:0] id, logic [2:0] nice,
			logic [31:0] runtime);
		@(negedge clk);
		start <= 1'b1;
		kind <= op;
		task_id <= id;
		nice_level <= nice;
		initial_runtime <= runtime;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(schedule_op(op, id, nice, runtime));
	endtask

	task automatic wait_drained();
		idle_for(1);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_weight(weight_reg_t idx, weight_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		level_weight[idx] = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		repeat (gap_len()) @(negedge clk);
	endtask

	task automatic set_weights(weight_t w0, weight_t w1, weight_t w2, weight_t w3,
			weight_t w4);
		write_weight(REG_WEIGHT_LEVEL0, w0);
		write_weight(REG_WEIGHT_LEVEL1, w1);
		write_weight(REG_WEIGHT_LEVEL2, w2);
		write_weight(REG_WEIGHT_LEVEL3, w3);
		write_weight(REG_WEIGHT_LEVEL4, w4);
	endtask

	// small values, clusters of equal runtimes, uniform values and values close to saturation
	function automatic logic [31:0] random_runtime();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2: return $urandom_range(0, 2000);
			3, 4: return 32'd500 * $urandom_range(0, 3);
			5, 6: return $urandom();
			7, 8: return 32'hFFFF_FFFF - $urandom_range(0, 70000);
			default: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
		endcase
	endfunction

	task automatic random_traffic(int unsigned items, int unsigned add_pct,
			int unsigned tick_pct, int unsigned dispatch_pct);
		int unsigned sel;
		kind_t       op;
		logic [2:0]  nice;
		repeat (items) begin
			sel = $urandom_range(0, 99);
			if (sel < add_pct)
				op = KIND_ADD;
			else if (sel < add_pct + tick_pct)
				op = KIND_TICK;
			else if (sel < add_pct + tick_pct + dispatch_pct)
				op = KIND_DISPATCH;
			else
				op = KIND_REMOVE;
			nice = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
				: 3'($urandom_range(5, 7));
			idle_for(gap_len());
			send_request(op, 16'($urandom_range(0, 16'hFFFF)), nice, random_runtime());
		end
		wait_drained();
	endtask

	task automatic test_empty_store_ops();
		send_request(KIND_TICK, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
		send_request(KIND_DISPATCH, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_REMOVE, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		wait_drained();
	endtask

	task automatic test_order_and_charge();
		send_request(KIND_ADD, 16'h0000, 3'd0, 32'd1000);
		send_request(KIND_ADD, 16'hFFFF, 3'd7, 32'd1000);
		send_request(KIND_ADD, 16'h1234, 3'd2, 32'd0);
		send_request(KIND_ADD, 16'h00AA, 3'd5, 32'hFFFF_FFFF);
		send_request(KIND_ADD, 16'h5555, 3'd3, 32'd1000);
		send_request(KIND_DISPATCH, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		// overwrites the running task
		send_request(KIND_DISPATCH, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_REMOVE, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_REMOVE, 16'h0000, 3'd0, 32'd0);
		wait_drained();
	endtask

	task automatic test_weight_registers();
		set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(KIND_ADD, 16'h0F0F, 3'd4, 32'hFFFF_0000);
		send_request(KIND_DISPATCH, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		// saturates at the top
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		wait_drained();
		set_weights(16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
		send_request(KIND_ADD, 16'hA5A5, 3'd1, 32'd7);
		send_request(KIND_DISPATCH, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_TICK, 16'h0000, 3'd0, 32'd0);
		send_request(KIND_REMOVE, 16'h0000, 3'd0, 32'd0);
		wait_drained();
	endtask

	task automatic test_balanced_traffic();
		set_weights(WEIGHT_RESET[0], WEIGHT_RESET[1], WEIGHT_RESET[2], WEIGHT_RESET[3],
			WEIGHT_RESET[4]);
		gaps_enabled = 1'b1;
		random_traffic(500, 35, 35, 15);
	endtask

	task automatic test_full_store_traffic();
		set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_traffic(400, 70, 20, 5);
	endtask

	task automatic test_back_to_back_traffic();
		set_weights(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		gaps_enabled = 1'b0;
		random_traffic(300, 40, 35, 15);
		gaps_enabled = 1'b1;
	endtask

	task automatic test_drain_traffic();
		set_weights(16'd0, 16'($urandom_range(1, 16'hFFFF)),
			16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
			16'($urandom_range(1, 16'hFFFF)));
		random_traffic(300, 25, 20, 10);
	endtask

	task automatic test_random_weights_traffic();
		set_weights(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
			16'($urandom_range(1, 1000)), 16'($urandom_range(1, 1000)),
			16'($urandom_range(1, 16'hFFFF)));
		random_traffic(250, 35, 40, 15);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			got_res.id = out_task_id;
			got_res.nice = out_nice_level;
			got_res.runtime = out_runtime;
			got_res.given = task_given;
			got_res.status = status_t'(status);
			got_res.count = queued_count;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_MISMATCHES)
					$display("unexpected result: id %h nice %0d runtime %h ",
						got_res.id, got_res.nice, got_res.runtime,
						"given %b status %0d count %0d",
						got_res.given, got_res.status, got_res.count);
			end else begin
				exp_res = expected_results.pop_front();
				if (got_res.id !== exp_res.id || got_res.nice !== exp_res.nice ||
						got_res.runtime !== exp_res.runtime ||
						got_res.given !== exp_res.given ||
						got_res.status !== exp_res.status ||
						got_res.count !== exp_res.count) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_MISMATCHES)
						$display("mismatch: expected id %h nice %0d runtime %h ",
							exp_res.id, exp_res.nice, exp_res.runtime,
							"given %b status %0d count %0d, ",
							exp_res.given, exp_res.status, exp_res.count,
							"got id %h nice %0d runtime %h ",
							got_res.id, got_res.nice, got_res.runtime,
							"given %b status %0d count %0d",
							got_res.given, got_res.status, got_res.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_ADD;
		task_id = '0;
		nice_level = '0;
		initial_runtime = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WEIGHT_LEVEL0;
		cfg_data = '0;
		mismatch_count = 0;
		cycle_count = 0;
		gaps_enabled = 1'b1;
		running_task = '0;
		running_valid = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++)
			level_weight[i] = WEIGHT_RESET[i];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_empty_store_ops();
		test_order_and_charge();
		test_weight_registers();
		test_balanced_traffic();
		test_full_store_traffic();
		test_back_to_back_traffic();
		test_drain_traffic();
		test_random_weights_traffic();

		wait_drained();
		mismatch_count += expected_results.size();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== weighted_runtime_task_scheduler.f =====
hdl/wrts_pkg.sv
hdl/wrts_cell.sv
hdl/weighted_runtime_task_scheduler.sv
hdl/wrts_checker.sv
dv/tb_weighted_runtime_task_scheduler.sv
